// File: design/owm_pkg.sv
// Package for the one-wire bus master: opcodes, register map, timing constants,
// shared item/config/result structs and small timing helper functions.
// No dependencies; used by owm_regs, owm_core and one_wire_bus_master.
`timescale 1ns / 1ps
`default_nettype none

package owm_pkg;

	// Width of the microsecond timer.
	localparam int TIMER_BITS = 16;
	localparam logic [31:0] TIMER_MAX32 = 32'((64'd1 << TIMER_BITS) - 64'd1);

	typedef logic [TIMER_BITS-1:0] timer_t;

	// Command codes carried in the opcode field.
	localparam logic [2:0] OP_TICK       = 3'd0;
	localparam logic [2:0] OP_RESET      = 3'd1;
	localparam logic [2:0] OP_WRITE_BYTE = 3'd2;
	localparam logic [2:0] OP_READ_BYTE  = 3'd3;
	localparam logic [2:0] OP_WRITE_BIT  = 3'd4;
	localparam logic [2:0] OP_READ_BIT   = 3'd5;
	localparam logic [2:0] OP_WAIT_LOW   = 3'd6;
	localparam logic [2:0] OP_WAIT_HIGH  = 3'd7;

	// Register indexes (byte address = 4 * index).
	localparam int ADDR_BITS = 5;
	localparam logic [2:0] REG_BUS_ENABLE        = 3'd0;
	localparam logic [2:0] REG_RESET_LOW_US      = 3'd1;
	localparam logic [2:0] REG_PRESENCE_WAIT_US  = 3'd2;
	localparam logic [2:0] REG_PRESENCE_TAIL_US  = 3'd3;
	localparam logic [2:0] REG_WRITE_ONE_LOW_US  = 3'd4;
	localparam logic [2:0] REG_WRITE_ZERO_LOW_US = 3'd5;
	localparam logic [2:0] REG_READ_LOW_US       = 3'd6;
	localparam logic [2:0] REG_READ_SAMPLE_US    = 3'd7;

	// Register reset values.
	localparam logic [9:0] RST_RESET_LOW_US      = 10'd480;
	localparam logic [7:0] RST_PRESENCE_WAIT_US  = 8'd60;
	localparam logic [7:0] RST_PRESENCE_TAIL_US  = 8'd100;
	localparam logic [5:0] RST_WRITE_ONE_LOW_US  = 6'd5;
	localparam logic [6:0] RST_WRITE_ZERO_LOW_US = 7'd70;
	localparam logic [3:0] RST_READ_LOW_US       = 4'd1;
	localparam logic [5:0] RST_READ_SAMPLE_US    = 6'd5;

	// Fixed slot recovery and read tail times.
	localparam timer_t REC_ONE_US  = timer_t'(60);
	localparam timer_t REC_ZERO_US = timer_t'(2);
	localparam timer_t RD_TAIL_US  = timer_t'(55);

	typedef struct packed {
		logic       bus_enable;
		logic [9:0] reset_low_us;
		logic [7:0] presence_wait_us;
		logic [7:0] presence_tail_us;
		logic [5:0] write_one_low_us;
		logic [6:0] write_zero_low_us;
		logic [3:0] read_low_us;
		logic [5:0] read_sample_us;
	} cfg_t;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [7:0]  data_in;
		logic [15:0] pre_delay;
		logic        bus_level;
	} item_t;

	typedef struct packed {
		logic       drive_low;
		logic       busy_res;
		logic       done_res;
		logic       success;
		logic [7:0] read_data;
		logic       rejected;
	} res_t;

	// A programmed time of zero counts as one microsecond.
	function automatic timer_t dur_us(input logic [9:0] d);
		timer_t t;
		t = (d == 10'd0) ? timer_t'(1) : timer_t'(d);
		return t;
	endfunction

	// Pre-delay of the wait commands, saturated to the timer range.
	function automatic timer_t sat_delay(input logic [15:0] d);
		logic [31:0] w;
		w = 32'(d);
		return (w > TIMER_MAX32) ? timer_t'(TIMER_MAX32) : timer_t'(w);
	endfunction

endpackage

`default_nettype wire

// File: design/owm_regs.sv
// APB-style configuration register file of the one-wire bus master.
// Depends on owm_pkg for the register map, reset values and cfg_t.
`timescale 1ns / 1ps
`default_nettype none

module owm_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [owm_pkg::ADDR_BITS-1:0]  paddr,
	input  wire logic [31:0]                    pwdata,
	output logic      [31:0]                    prdata,
	output logic                                pready,
	output owm_pkg::cfg_t                       cfg
);

	owm_pkg::cfg_t cfg_q;
	logic [2:0]    idx;
	logic          wr_en;

	assign idx    = paddr[4:2];
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bus_enable        <= 1'b0;
			cfg_q.reset_low_us      <= owm_pkg::RST_RESET_LOW_US;
			cfg_q.presence_wait_us  <= owm_pkg::RST_PRESENCE_WAIT_US;
			cfg_q.presence_tail_us  <= owm_pkg::RST_PRESENCE_TAIL_US;
			cfg_q.write_one_low_us  <= owm_pkg::RST_WRITE_ONE_LOW_US;
			cfg_q.write_zero_low_us <= owm_pkg::RST_WRITE_ZERO_LOW_US;
			cfg_q.read_low_us       <= owm_pkg::RST_READ_LOW_US;
			cfg_q.read_sample_us    <= owm_pkg::RST_READ_SAMPLE_US;
		end else if (wr_en) begin
			unique case (idx)
				owm_pkg::REG_BUS_ENABLE:        cfg_q.bus_enable        <= pwdata[0];
				owm_pkg::REG_RESET_LOW_US:      cfg_q.reset_low_us      <= pwdata[9:0];
				owm_pkg::REG_PRESENCE_WAIT_US:  cfg_q.presence_wait_us  <= pwdata[7:0];
				owm_pkg::REG_PRESENCE_TAIL_US:  cfg_q.presence_tail_us  <= pwdata[7:0];
				owm_pkg::REG_WRITE_ONE_LOW_US:  cfg_q.write_one_low_us  <= pwdata[5:0];
				owm_pkg::REG_WRITE_ZERO_LOW_US: cfg_q.write_zero_low_us <= pwdata[6:0];
				owm_pkg::REG_READ_LOW_US:       cfg_q.read_low_us       <= pwdata[3:0];
				owm_pkg::REG_READ_SAMPLE_US:    cfg_q.read_sample_us    <= pwdata[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = 32'd0;
		unique case (idx)
			owm_pkg::REG_BUS_ENABLE:        prdata = 32'(cfg_q.bus_enable);
			owm_pkg::REG_RESET_LOW_US:      prdata = 32'(cfg_q.reset_low_us);
			owm_pkg::REG_PRESENCE_WAIT_US:  prdata = 32'(cfg_q.presence_wait_us);
			owm_pkg::REG_PRESENCE_TAIL_US:  prdata = 32'(cfg_q.presence_tail_us);
			owm_pkg::REG_WRITE_ONE_LOW_US:  prdata = 32'(cfg_q.write_one_low_us);
			owm_pkg::REG_WRITE_ZERO_LOW_US: prdata = 32'(cfg_q.write_zero_low_us);
			owm_pkg::REG_READ_LOW_US:       prdata = 32'(cfg_q.read_low_us);
			owm_pkg::REG_READ_SAMPLE_US:    prdata = 32'(cfg_q.read_sample_us);
			default:                        prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

// File: design/owm_core.sv
// Bus sequencer of the one-wire bus master: phase, timer and shift state, and the
// combinational next-state and result logic for one item. Depends on owm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module owm_core (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           step,
	input  wire owm_pkg::item_t item,
	input  wire owm_pkg::cfg_t  cfg,
	output owm_pkg::res_t       res
);

	typedef enum logic [3:0] {
		PH_IDLE      = 4'd0,
		PH_RST_LOW   = 4'd1,
		PH_RST_WAIT  = 4'd2,
		PH_RST_TAIL  = 4'd3,
		PH_SLOT_LOW  = 4'd4,
		PH_WR_REC    = 4'd5,
		PH_RD_SAMPLE = 4'd6,
		PH_RD_TAIL   = 4'd7,
		PH_WAIT_PRE  = 4'd8,
		PH_WAIT_POLL = 4'd9
	} phase_t;

	phase_t          phase_q, phase_n;
	logic [2:0]      op_kind_q, op_kind_n;
	owm_pkg::timer_t timer_q, timer_n, timer_dec;
	logic [7:0]      shift_q, shift_n;
	logic [3:0]      bits_q, bits_n, bits_dec;
	logic            drive_q, drive_n;
	logic            expired, poll, done, ok, rej;
	logic [7:0]      data;
	logic            is_write;

	// Shared one-microsecond countdown.
	assign expired   = (timer_q <= owm_pkg::timer_t'(1));
	assign timer_dec = expired ? '0 : timer_q - owm_pkg::timer_t'(1);
	assign bits_dec  = bits_q - 4'd1;
	assign is_write  = (op_kind_q == owm_pkg::OP_WRITE_BYTE) ||
		(op_kind_q == owm_pkg::OP_WRITE_BIT);

	always_comb begin
		phase_n   = phase_q;
		op_kind_n = op_kind_q;
		timer_n   = timer_q;
		shift_n   = shift_q;
		bits_n    = bits_q;
		drive_n   = drive_q;
		poll      = 1'b0;
		done      = 1'b0;
		ok        = 1'b0;
		rej       = 1'b0;
		data      = 8'd0;

		if (item.opcode != owm_pkg::OP_TICK) begin
			if (phase_q != PH_IDLE) begin
				rej = 1'b1;
			end else if (!cfg.bus_enable) begin
				done    = 1'b1;
				drive_n = 1'b0;
			end else begin
				op_kind_n = item.opcode;
				unique case (item.opcode)
					owm_pkg::OP_RESET: begin
						drive_n = 1'b1;
						phase_n = PH_RST_LOW;
						timer_n = owm_pkg::dur_us(cfg.reset_low_us);
					end
					owm_pkg::OP_WRITE_BYTE, owm_pkg::OP_WRITE_BIT: begin
						shift_n = (item.opcode == owm_pkg::OP_WRITE_BYTE) ?
							item.data_in : {7'd0, item.data_in[0]};
						bits_n  = (item.opcode == owm_pkg::OP_WRITE_BYTE) ? 4'd8 : 4'd1;
						drive_n = 1'b1;
						phase_n = PH_SLOT_LOW;
						timer_n = item.data_in[0] ?
							owm_pkg::dur_us(10'(cfg.write_one_low_us)) :
							owm_pkg::dur_us(10'(cfg.write_zero_low_us));
					end
					owm_pkg::OP_READ_BYTE, owm_pkg::OP_READ_BIT: begin
						shift_n = 8'd0;
						bits_n  = (item.opcode == owm_pkg::OP_READ_BYTE) ? 4'd8 : 4'd1;
						drive_n = 1'b1;
						phase_n = PH_SLOT_LOW;
						timer_n = owm_pkg::dur_us(10'(cfg.read_low_us));
					end
					default: begin
						// Wait while low or wait while high.
						drive_n = 1'b0;
						if (item.pre_delay == 16'd0) begin
							phase_n = PH_WAIT_POLL;
							timer_n = '0;
						end else begin
							phase_n = PH_WAIT_PRE;
							timer_n = owm_pkg::sat_delay(item.pre_delay);
						end
					end
				endcase
			end
		end else begin
			unique case (phase_q)
				PH_IDLE: ;
				PH_RST_LOW: begin
					timer_n = timer_dec;
					if (expired) begin
						drive_n = 1'b0;
						phase_n = PH_RST_WAIT;
						timer_n = owm_pkg::dur_us(10'(cfg.presence_wait_us));
					end
				end
				PH_RST_WAIT: begin
					timer_n = timer_dec;
					if (expired) begin
						if (!item.bus_level) begin
							if (cfg.presence_tail_us == 8'd0) begin
								done = 1'b1;
								ok   = 1'b1;
							end else begin
								phase_n = PH_RST_TAIL;
								timer_n = owm_pkg::timer_t'(cfg.presence_tail_us);
							end
						end else begin
							done = 1'b1;
						end
					end
				end
				PH_RST_TAIL: begin
					timer_n = timer_dec;
					if (expired) begin
						done = 1'b1;
						ok   = 1'b1;
					end
				end
				PH_SLOT_LOW: begin
					timer_n = timer_dec;
					if (expired) begin
						drive_n = 1'b0;
						if (is_write) begin
							phase_n = PH_WR_REC;
							timer_n = shift_q[0] ? owm_pkg::REC_ONE_US : owm_pkg::REC_ZERO_US;
						end else begin
							phase_n = PH_RD_SAMPLE;
							timer_n = owm_pkg::dur_us(10'(cfg.read_sample_us));
						end
					end
				end
				PH_WR_REC: begin
					timer_n = timer_dec;
					if (expired) begin
						bits_n = bits_dec;
						if (bits_dec == 4'd0) begin
							done = 1'b1;
							ok   = 1'b1;
						end else begin
							// Next bit: shift and open a new write slot.
							shift_n = {1'b0, shift_q[7:1]};
							drive_n = 1'b1;
							phase_n = PH_SLOT_LOW;
							timer_n = shift_q[1] ?
								owm_pkg::dur_us(10'(cfg.write_one_low_us)) :
								owm_pkg::dur_us(10'(cfg.write_zero_low_us));
						end
					end
				end
				PH_RD_SAMPLE: begin
					timer_n = timer_dec;
					if (expired) begin
						shift_n = (op_kind_q == owm_pkg::OP_READ_BYTE) ?
							{item.bus_level, shift_q[7:1]} : {7'd0, item.bus_level};
						phase_n = PH_RD_TAIL;
						timer_n = owm_pkg::RD_TAIL_US;
					end
				end
				PH_RD_TAIL: begin
					timer_n = timer_dec;
					if (expired) begin
						bits_n = bits_dec;
						if (bits_dec == 4'd0) begin
							done = 1'b1;
							ok   = 1'b1;
							data = (op_kind_q == owm_pkg::OP_READ_BYTE) ?
								shift_q : {7'd0, shift_q[0]};
						end else begin
							drive_n = 1'b1;
							phase_n = PH_SLOT_LOW;
							timer_n = owm_pkg::dur_us(10'(cfg.read_low_us));
						end
					end
				end
				PH_WAIT_PRE: begin
					timer_n = timer_dec;
					if (expired) begin
						phase_n = PH_WAIT_POLL;
						poll    = 1'b1;
					end
				end
				PH_WAIT_POLL: poll = 1'b1;
				default: phase_n = PH_IDLE;
			endcase

			if (poll && (((op_kind_q == owm_pkg::OP_WAIT_LOW) && item.bus_level) ||
				((op_kind_q == owm_pkg::OP_WAIT_HIGH) && !item.bus_level))) begin
				done = 1'b1;
				ok   = 1'b1;
			end
			if (done) begin
				phase_n = PH_IDLE;
				drive_n = 1'b0;
				timer_n = '0;
			end
		end

		res.drive_low = drive_n;
		res.busy_res  = (phase_n != PH_IDLE);
		res.done_res  = done;
		res.success   = ok;
		res.read_data = data;
		res.rejected  = rej;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			op_kind_q <= owm_pkg::OP_TICK;
			timer_q   <= '0;
			shift_q   <= 8'd0;
			bits_q    <= 4'd0;
			drive_q   <= 1'b0;
		end else if (step) begin
			phase_q   <= phase_n;
			op_kind_q <= op_kind_n;
			timer_q   <= timer_n;
			shift_q   <= shift_n;
			bits_q    <= bits_n;
			drive_q   <= drive_n;
		end
	end

endmodule

`default_nettype wire

// File: design/one_wire_bus_master.sv
// One-wire bus master. Every input item is either a tick, which advances bus
// time by one microsecond and carries the line level sampled in that microsecond,
// or a command (reset with presence detect, write or read of a byte LSB first,
// write or read of a single bit, or wait while low / wait while high after a
// pre-delay). Every item yields exactly one result item giving the open-drain
// drive level, busy, done, success, read data and a rejected flag for a command
// that arrived while an operation was still running. An item is registered at
// the input, passes the sequencer's combinational next-state logic and lands in
// an output register; one item is taken every cycle as long as the output side
// keeps taking results. While a finished result waits in the output register,
// one more item can still be taken into the input register; after that the
// input stalls until the result is taken.
// Timing settings are written through the APB-style port at byte address
// 4 * index and should only be changed while the bus is idle. While bus_enable
// is 0 a command taken while idle completes at once with failure and zero data.
// Depends on owm_pkg, owm_regs and owm_core.
`timescale 1ns / 1ps
`default_nettype none

module one_wire_bus_master (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Configuration port.
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [owm_pkg::ADDR_BITS-1:0] paddr,
	input  wire logic [31:0]                   pwdata,
	output logic      [31:0]                   prdata,
	output logic                               pready,
	// Input item channel.
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [2:0]                    opcode,
	input  wire logic [7:0]                    data_in,
	input  wire logic [15:0]                   pre_delay,
	input  wire logic                          bus_level,
	// Result item channel.
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic                               drive_low,
	output logic                               busy_res,
	output logic                               done_res,
	output logic                               success,
	output logic      [7:0]                    read_data,
	output logic                               rejected
);

	owm_pkg::cfg_t  cfg;
	owm_pkg::item_t item_s1;
	logic           valid_s1;
	owm_pkg::res_t  res_comb;
	owm_pkg::res_t  res_s2;
	logic           valid_s2;
	logic           adv_s2;
	logic           step;

	owm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The result register can load when it is empty or being emptied this cycle.
	assign adv_s2   = !valid_s2 || out_ready;
	// The sequencer state moves only when the registered item passes to the output.
	assign step     = valid_s1 && adv_s2;
	assign in_ready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.opcode    <= opcode;
			item_s1.data_in   <= data_in;
			item_s1.pre_delay <= pre_delay;
			item_s1.bus_level <= bus_level;
		end
	end

	owm_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s2 <= res_comb;
		end
	end

	assign out_valid = valid_s2;
	assign drive_low = res_s2.drive_low;
	assign busy_res  = res_s2.busy_res;
	assign done_res  = res_s2.done_res;
	assign success   = res_s2.success;
	assign read_data = res_s2.read_data;
	assign rejected  = res_s2.rejected;

endmodule

`default_nettype wire
